FILE: sv/rbbp_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, types and the arctangent table of the bearing block.
package rbbp_pkg;

	localparam int COORD_WIDTH     = 16;
	localparam int CORDIC_STAGES   = 16;
	localparam int ATAN_ENTRIES    = 24;

	localparam int DIFF_W          = COORD_WIDTH + 1;
	localparam int CFG_W           = 16;
	localparam int PROD_W          = DIFF_W + CFG_W;
	localparam int ROT_W           = PROD_W + 1;
	localparam int MAG_W           = COORD_WIDTH + 16;
	localparam int PRE_SCALE_SHIFT = 40 - COORD_WIDTH;
	localparam int XY_W            = MAG_W + PRE_SCALE_SHIFT + 4;
	localparam int Z_W             = 32;
	localparam int ROUND_SHIFT     = 16;
	localparam int ANGLE_W         = 14;
	localparam int BEARING_W       = 16;
	localparam int IN_TDATA_W      = ((4 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W     = 16;
	localparam int CFG_INDEX_W     = 1;

	localparam logic signed [Z_W-1:0] QUARTER_FINE = 32'sd754974720;
	localparam logic signed [Z_W-1:0] ROUND_HALF   = 32'sd32768;

	localparam logic signed [BEARING_W-1:0] HALF_TURN    = 16'sd23040;
	localparam logic signed [BEARING_W-1:0] QUARTER_TURN = 16'sd11520;

	localparam logic [CFG_INDEX_W-1:0] REG_COSINE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SINE   = 1'b1;

	localparam logic signed [CFG_W-1:0] COSINE_RESET = 16'sd16384;
	localparam logic signed [CFG_W-1:0] SINE_RESET   = 16'sd0;

	typedef struct packed {
		logic                        special;
		logic signed [BEARING_W-1:0] value;
		logic                        x_neg;
		logic                        y_neg;
	} rbbp_tag_t;

	function automatic logic signed [Z_W-1:0] atan_fine(input int idx);
		logic signed [Z_W-1:0] r;
		case (idx)
			0:       r = 32'sd377487360;
			1:       r = 32'sd222843801;
			2:       r = 32'sd117744544;
			3:       r = 32'sd59768969;
			4:       r = 32'sd30000467;
			5:       r = 32'sd15014858;
			6:       r = 32'sd7509261;
			7:       r = 32'sd3754860;
			8:       r = 32'sd1877459;
			9:       r = 32'sd938733;
			10:      r = 32'sd469367;
			11:      r = 32'sd234683;
			12:      r = 32'sd117342;
			13:      r = 32'sd58671;
			14:      r = 32'sd29335;
			15:      r = 32'sd14668;
			16:      r = 32'sd7334;
			17:      r = 32'sd3667;
			18:      r = 32'sd1833;
			19:      r = 32'sd917;
			20:      r = 32'sd458;
			21:      r = 32'sd229;
			22:      r = 32'sd115;
			23:      r = 32'sd57;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/rbbp_cordic.sv
`timescale 1ns / 1ps
// Unrolled vectoring CORDIC pipeline, one register stage per iteration.
module rbbp_cordic (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [rbbp_pkg::MAG_W-1:0]                num,
	input  logic [rbbp_pkg::MAG_W-1:0]                den,
	input  rbbp_pkg::rbbp_tag_t                       in_tag,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [rbbp_pkg::Z_W-1:0]           angle,
	output rbbp_pkg::rbbp_tag_t                       out_tag
);

	localparam int N  = (rbbp_pkg::CORDIC_STAGES > rbbp_pkg::ATAN_ENTRIES) ?
		rbbp_pkg::ATAN_ENTRIES : rbbp_pkg::CORDIC_STAGES;
	localparam int XW = rbbp_pkg::XY_W;
	localparam int ZW = rbbp_pkg::Z_W;
	localparam int PAD_W = XW - rbbp_pkg::MAG_W - rbbp_pkg::PRE_SCALE_SHIFT;

	logic signed [XW-1:0] x_in;
	logic signed [XW-1:0] y_in;
	logic signed [XW-1:0] x_s [N];
	logic signed [XW-1:0] y_s [N];
	logic signed [ZW-1:0] z_s [N];
	rbbp_pkg::rbbp_tag_t  tag_s [N];
	logic [N-1:0]         v_s;
	logic [N-1:0]         en;

	assign x_in = $signed({{PAD_W{1'b0}}, den, {rbbp_pkg::PRE_SCALE_SHIFT{1'b0}}});
	assign y_in = $signed({{PAD_W{1'b0}}, num, {rbbp_pkg::PRE_SCALE_SHIFT{1'b0}}});

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_iter
			logic signed [XW-1:0] xp;
			logic signed [XW-1:0] yp;
			logic signed [ZW-1:0] zp;
			logic                 vp;
			rbbp_pkg::rbbp_tag_t  tp;
			logic                 nr;

			if (k == 0) begin : g_first
				assign xp = x_in;
				assign yp = y_in;
				assign zp = '0;
				assign vp = in_valid;
				assign tp = in_tag;
			end else begin : g_next
				assign xp = x_s[k-1];
				assign yp = y_s[k-1];
				assign zp = z_s[k-1];
				assign vp = v_s[k-1];
				assign tp = tag_s[k-1];
			end

			if (k == N - 1) begin : g_last
				assign nr = out_ready;
			end else begin : g_mid
				assign nr = en[k+1];
			end

			assign en[k] = !v_s[k] || nr;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= vp;
				end
			end

			always_ff @(posedge clk) begin
				if (en[k] && vp) begin
					tag_s[k] <= tp;
					if (yp > 0) begin
						x_s[k] <= xp + (yp >>> k);
						y_s[k] <= yp - (xp >>> k);
						z_s[k] <= zp + rbbp_pkg::atan_fine(k);
					end else begin
						x_s[k] <= xp - (yp >>> k);
						y_s[k] <= yp + (xp >>> k);
						z_s[k] <= zp - rbbp_pkg::atan_fine(k);
					end
				end
			end
		end
	endgenerate

	assign in_ready  = en[0];
	assign out_valid = v_s[N-1];
	assign angle     = z_s[N-1];
	assign out_tag   = tag_s[N-1];

endmodule

FILE: sv/rotated_bearing_between_points.sv
`timescale 1ns / 1ps
// Top level of the rotated compass bearing block.
// Each beat carries a start and a target point; the difference vector is turned by the
// configured offset cosine and sine (signed Q2.14) and its bearing, clockwise from +y,
// comes out in 1/128 degree in the range -23040..23040. The block takes one beat per
// cycle while the output side does not stall. Registers hold, in order, the difference,
// the products, the sums and the magnitudes, then one per CORDIC iteration, then the
// final rounding and quadrant fold. Results leave in order and a stall on the output
// side holds every beat in flight. The offset registers should be written only while
// no beat is in flight.
module rotated_bearing_between_points (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rbbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rbbp_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// Fields from bit 0 up: start_x, start_y, target_x, target_y.
	input  logic [rbbp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// Fields from bit 0 up: bearing.
	output logic [rbbp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int CW  = rbbp_pkg::COORD_WIDTH;
	localparam int DW  = rbbp_pkg::DIFF_W;
	localparam int PW  = rbbp_pkg::PROD_W;
	localparam int RW  = rbbp_pkg::ROT_W;
	localparam int MW  = rbbp_pkg::MAG_W;
	localparam int ZW  = rbbp_pkg::Z_W;
	localparam int AW  = rbbp_pkg::ANGLE_W;
	localparam int BW  = rbbp_pkg::BEARING_W;
	localparam int RS  = rbbp_pkg::ROUND_SHIFT;

	logic signed [rbbp_pkg::CFG_W-1:0] cos_q;
	logic signed [rbbp_pkg::CFG_W-1:0] sin_q;

	logic signed [CW-1:0] start_x;
	logic signed [CW-1:0] start_y;
	logic signed [CW-1:0] target_x;
	logic signed [CW-1:0] target_y;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                 en_s1, en_s2, en_s3, en_s4, en_s5;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [PW-1:0] dxc_s2, dys_s2, dyc_s2, dxs_s2;
	logic signed [RW-1:0] rx_s3, ry_s3;
	logic [MW-1:0]        num_s4, den_s4;
	rbbp_pkg::rbbp_tag_t  tag_s4;
	logic signed [BW-1:0] bearing_s5;

	logic signed [RW-1:0] rx_abs, ry_abs;
	rbbp_pkg::rbbp_tag_t  tag_next;

	logic                 c_in_ready;
	logic                 c_out_valid;
	logic signed [ZW-1:0] c_angle;
	rbbp_pkg::rbbp_tag_t  c_tag;

	logic signed [ZW-1:0] z_clamped;
	logic signed [ZW-1:0] z_rounded;
	logic signed [BW-1:0] a_ext;
	logic signed [BW-1:0] bearing_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= rbbp_pkg::COSINE_RESET;
			sin_q <= rbbp_pkg::SINE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbbp_pkg::REG_COSINE: cos_q <= cfg_data;
				rbbp_pkg::REG_SINE:   sin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign start_x  = s_axis_tdata[CW-1:0];
	assign start_y  = s_axis_tdata[2*CW-1:CW];
	assign target_x = s_axis_tdata[3*CW-1:2*CW];
	assign target_y = s_axis_tdata[4*CW-1:3*CW];

	assign en_s1 = !v_s1 || en_s2;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s4 = !v_s4 || c_in_ready;
	assign en_s5 = !v_s5 || m_axis_tready;

	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= c_out_valid;
			end
		end
	end

	always_comb begin
		rx_abs = rx_s3[RW-1] ? -rx_s3 : rx_s3;
		ry_abs = ry_s3[RW-1] ? -ry_s3 : ry_s3;
		tag_next.x_neg   = rx_s3[RW-1];
		tag_next.y_neg   = ry_s3[RW-1];
		tag_next.special = (rx_s3 == '0) || (ry_s3 == '0);
		if (rx_s3 == '0 && ry_s3 != '0) begin
			tag_next.value = ry_s3[RW-1] ? rbbp_pkg::HALF_TURN : '0;
		end else if (ry_s3 == '0 && rx_s3 != '0) begin
			tag_next.value = rx_s3[RW-1] ? -rbbp_pkg::QUARTER_TURN : rbbp_pkg::QUARTER_TURN;
		end else begin
			tag_next.value = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			dx_s1 <= DW'(target_x) - DW'(start_x);
			dy_s1 <= DW'(target_y) - DW'(start_y);
		end
		if (en_s2 && v_s1) begin
			dxc_s2 <= dx_s1 * cos_q;
			dys_s2 <= dy_s1 * sin_q;
			dyc_s2 <= dy_s1 * cos_q;
			dxs_s2 <= dx_s1 * sin_q;
		end
		if (en_s3 && v_s2) begin
			rx_s3 <= RW'(dxc_s2) + RW'(dys_s2);
			ry_s3 <= RW'(dyc_s2) - RW'(dxs_s2);
		end
		if (en_s4 && v_s3) begin
			num_s4 <= rx_abs[MW-1:0];
			den_s4 <= ry_abs[MW-1:0];
			tag_s4 <= tag_next;
		end
		if (en_s5 && c_out_valid) begin
			bearing_s5 <= bearing_next;
		end
	end

	rbbp_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (c_in_ready),
		.num       (num_s4),
		.den       (den_s4),
		.in_tag    (tag_s4),
		.out_valid (c_out_valid),
		.out_ready (en_s5),
		.angle     (c_angle),
		.out_tag   (c_tag)
	);

	always_comb begin
		if (c_angle < 0) begin
			z_clamped = '0;
		end else if (c_angle > rbbp_pkg::QUARTER_FINE) begin
			z_clamped = rbbp_pkg::QUARTER_FINE;
		end else begin
			z_clamped = c_angle;
		end
		z_rounded = z_clamped + rbbp_pkg::ROUND_HALF;
		a_ext = $signed({{(BW-AW){1'b0}}, z_rounded[RS+AW-1:RS]});
		if (c_tag.special) begin
			bearing_next = c_tag.value;
		end else begin
			case ({c_tag.x_neg, c_tag.y_neg})
				2'b00:   bearing_next = a_ext;
				2'b10:   bearing_next = -a_ext;
				2'b01:   bearing_next = rbbp_pkg::HALF_TURN - a_ext;
				default: bearing_next = a_ext - rbbp_pkg::HALF_TURN;
			endcase
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = bearing_s5;

endmodule
